[src/dpws_pkg.sv]
// Package for the dual PID drive controller: fixed widths, register map,
// microcode encoding and the microcode program itself.
// Depends on nothing; every other file of the block but dpws_req_if uses it.
package dpws_pkg;

   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int TOTAL_BITS     = GAIN_BITS + 1;
   localparam int DRIVE_BITS     = 8;
   localparam int DRIVE_MAX      = 127;
   localparam int ACCUM_WINDOW   = 1000;
   localparam int WINDOW_BITS    = 11;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_SETPOINT_LEFT     = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_SETPOINT_RIGHT    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_GAIN_P            = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_GAIN_I            = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_GAIN_D            = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_STRAIGHTEN_GAIN   = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_INTEGRAL_LIMIT    = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_STRAIGHTEN_OFFSET = 3'd7;

   localparam logic [GAIN_BITS-1:0] GAIN_P_RESET          = 16'd333;
   localparam logic [GAIN_BITS-1:0] GAIN_I_RESET          = 16'd26;
   localparam logic [GAIN_BITS-1:0] GAIN_D_RESET          = 16'd51;
   localparam logic [GAIN_BITS-1:0] STRAIGHTEN_GAIN_RESET = 16'd256;
   localparam logic [GAIN_BITS-1:0] INTEGRAL_LIMIT_RESET  = 16'd500;
   localparam int                   OFFSET_RESET          = 200;

   localparam int OP_BITS   = 5;
   localparam int COND_BITS = 3;
   localparam int UPC_BITS  = 6;

   localparam logic [OP_BITS-1:0] OP_NOP       = 5'd0;
   localparam logic [OP_BITS-1:0] OP_ACCEPT    = 5'd1;
   localparam logic [OP_BITS-1:0] OP_ERR       = 5'd2;
   localparam logic [OP_BITS-1:0] OP_TSUM      = 5'd3;
   localparam logic [OP_BITS-1:0] OP_CLAMP     = 5'd4;
   localparam logic [OP_BITS-1:0] OP_MUL_P     = 5'd5;
   localparam logic [OP_BITS-1:0] OP_MUL_I     = 5'd6;
   localparam logic [OP_BITS-1:0] OP_MUL_D     = 5'd7;
   localparam logic [OP_BITS-1:0] OP_SUM       = 5'd8;
   localparam logic [OP_BITS-1:0] OP_CMP       = 5'd9;
   localparam logic [OP_BITS-1:0] OP_MUL_K     = 5'd10;
   localparam logic [OP_BITS-1:0] OP_OUT_PLAIN = 5'd11;
   localparam logic [OP_BITS-1:0] OP_OUT_MUL   = 5'd12;
   localparam logic [OP_BITS-1:0] OP_DIV_INIT  = 5'd13;
   localparam logic [OP_BITS-1:0] OP_DIV_STEP  = 5'd14;
   localparam logic [OP_BITS-1:0] OP_OUT_DIV   = 5'd15;
   localparam logic [OP_BITS-1:0] OP_EMIT      = 5'd16;

   localparam logic [COND_BITS-1:0] COND_NEXT      = 3'd0;
   localparam logic [COND_BITS-1:0] COND_ALWAYS    = 3'd1;
   localparam logic [COND_BITS-1:0] COND_NO_REQ    = 3'd2;
   localparam logic [COND_BITS-1:0] COND_SCALE_MUL = 3'd3;
   localparam logic [COND_BITS-1:0] COND_SCALE_DIV = 3'd4;
   localparam logic [COND_BITS-1:0] COND_DIV_BUSY  = 3'd5;
   localparam logic [COND_BITS-1:0] COND_OUT_FULL  = 3'd6;

   localparam logic SIDE_LEFT  = 1'b0;
   localparam logic SIDE_RIGHT = 1'b1;

   localparam logic [UPC_BITS-1:0] UPC_IDLE  = 6'd0;
   localparam logic [UPC_BITS-1:0] UPC_PID_L = 6'd1;
   localparam logic [UPC_BITS-1:0] UPC_PID_R = 6'd8;
   localparam logic [UPC_BITS-1:0] UPC_CMP   = 6'd15;
   localparam logic [UPC_BITS-1:0] UPC_SCL_L = 6'd16;
   localparam logic [UPC_BITS-1:0] UPC_SCL_R = 6'd24;
   localparam logic [UPC_BITS-1:0] UPC_OUT   = 6'd32;

   localparam logic [UPC_BITS-1:0] SCL_MUL  = 6'd3;
   localparam logic [UPC_BITS-1:0] SCL_DIV  = 6'd5;
   localparam logic [UPC_BITS-1:0] SCL_LOOP = 6'd6;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic                 side;
      logic [COND_BITS-1:0] cond;
      logic [UPC_BITS-1:0]  target;
   } ctrl_word_type;

   typedef struct packed {
      logic no_req;
      logic scale_mul;
      logic scale_div;
      logic div_busy;
      logic out_full;
   } seq_flags_type;

   function automatic ctrl_word_type uw(input logic [OP_BITS-1:0] op,
                                        input logic side,
                                        input logic [COND_BITS-1:0] cond,
                                        input logic [UPC_BITS-1:0] target);
      ctrl_word_type w;
      w.op     = op;
      w.side   = side;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // One PID pass per side, a compare, one scaling pass per side, then the result beat.
   function automatic ctrl_word_type ucode_rom(input logic [UPC_BITS-1:0] upc);
      ctrl_word_type w;
      case (upc)
         UPC_IDLE:          w = uw(OP_ACCEPT, SIDE_LEFT, COND_NO_REQ, UPC_IDLE);
         UPC_PID_L:         w = uw(OP_ERR, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_PID_L + 6'd1:  w = uw(OP_TSUM, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_PID_L + 6'd2:  w = uw(OP_CLAMP, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_PID_L + 6'd3:  w = uw(OP_MUL_P, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_PID_L + 6'd4:  w = uw(OP_MUL_I, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_PID_L + 6'd5:  w = uw(OP_MUL_D, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_PID_L + 6'd6:  w = uw(OP_SUM, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_PID_R:         w = uw(OP_ERR, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_PID_R + 6'd1:  w = uw(OP_TSUM, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_PID_R + 6'd2:  w = uw(OP_CLAMP, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_PID_R + 6'd3:  w = uw(OP_MUL_P, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_PID_R + 6'd4:  w = uw(OP_MUL_I, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_PID_R + 6'd5:  w = uw(OP_MUL_D, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_PID_R + 6'd6:  w = uw(OP_SUM, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_CMP:           w = uw(OP_CMP, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_SCL_L:         w = uw(OP_NOP, SIDE_LEFT, COND_SCALE_MUL, UPC_SCL_L + SCL_MUL);
         UPC_SCL_L + 6'd1:  w = uw(OP_NOP, SIDE_LEFT, COND_SCALE_DIV, UPC_SCL_L + SCL_DIV);
         UPC_SCL_L + 6'd2:  w = uw(OP_OUT_PLAIN, SIDE_LEFT, COND_ALWAYS, UPC_SCL_R);
         UPC_SCL_L + 6'd3:  w = uw(OP_MUL_K, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_SCL_L + 6'd4:  w = uw(OP_OUT_MUL, SIDE_LEFT, COND_ALWAYS, UPC_SCL_R);
         UPC_SCL_L + 6'd5:  w = uw(OP_DIV_INIT, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_SCL_L + 6'd6:  w = uw(OP_DIV_STEP, SIDE_LEFT, COND_DIV_BUSY,
                                   UPC_SCL_L + SCL_LOOP);
         UPC_SCL_L + 6'd7:  w = uw(OP_OUT_DIV, SIDE_LEFT, COND_NEXT, UPC_IDLE);
         UPC_SCL_R:         w = uw(OP_NOP, SIDE_RIGHT, COND_SCALE_MUL, UPC_SCL_R + SCL_MUL);
         UPC_SCL_R + 6'd1:  w = uw(OP_NOP, SIDE_RIGHT, COND_SCALE_DIV, UPC_SCL_R + SCL_DIV);
         UPC_SCL_R + 6'd2:  w = uw(OP_OUT_PLAIN, SIDE_RIGHT, COND_ALWAYS, UPC_OUT);
         UPC_SCL_R + 6'd3:  w = uw(OP_MUL_K, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_SCL_R + 6'd4:  w = uw(OP_OUT_MUL, SIDE_RIGHT, COND_ALWAYS, UPC_OUT);
         UPC_SCL_R + 6'd5:  w = uw(OP_DIV_INIT, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_SCL_R + 6'd6:  w = uw(OP_DIV_STEP, SIDE_RIGHT, COND_DIV_BUSY,
                                   UPC_SCL_R + SCL_LOOP);
         UPC_SCL_R + 6'd7:  w = uw(OP_OUT_DIV, SIDE_RIGHT, COND_NEXT, UPC_IDLE);
         UPC_OUT:           w = uw(OP_NOP, SIDE_LEFT, COND_OUT_FULL, UPC_OUT);
         UPC_OUT + 6'd1:    w = uw(OP_EMIT, SIDE_LEFT, COND_ALWAYS, UPC_IDLE);
         default:           w = uw(OP_NOP, SIDE_LEFT, COND_ALWAYS, UPC_IDLE);
      endcase
      return w;
   endfunction

endpackage

[src/dpws_req_if.sv]
// Request channel of the dual PID drive controller: one beat carries both position samples.
// Depends on nothing.
interface dpws_req_if #(
   parameter int SENSOR_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SENSOR_BITS-1:0] sensor_left;
   logic [SENSOR_BITS-1:0] sensor_right;

   modport source (output valid, sensor_left, sensor_right, input ready);
   modport sink (input valid, sensor_left, sensor_right, output ready);
endinterface

[src/dpws_rsp_if.sv]
// Response channel of the dual PID drive controller: one beat carries both drive commands.
// Depends on dpws_pkg for the drive width.
interface dpws_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [dpws_pkg::DRIVE_BITS-1:0] drive_left;
   logic signed [dpws_pkg::DRIVE_BITS-1:0] drive_right;

   modport source (output valid, drive_left, drive_right, input ready);
   modport sink (input valid, drive_left, drive_right, output ready);
endinterface

[src/dpws_seq.sv]
// Microcode sequencer: step counter, program ROM and conditional jump logic.
// Depends on dpws_pkg for the control word, the condition codes and the program.
module dpws_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  dpws_pkg::seq_flags_type flags,
   output dpws_pkg::ctrl_word_type ctrl
);

   logic [dpws_pkg::UPC_BITS-1:0] upc_ff;
   logic [dpws_pkg::UPC_BITS-1:0] upc_in;
   dpws_pkg::ctrl_word_type       word;
   logic                          take;

   always_comb begin
      word = dpws_pkg::ucode_rom(upc_ff);
      case (word.cond)
         dpws_pkg::COND_NEXT:      take = 1'b0;
         dpws_pkg::COND_ALWAYS:    take = 1'b1;
         dpws_pkg::COND_NO_REQ:    take = flags.no_req;
         dpws_pkg::COND_SCALE_MUL: take = flags.scale_mul;
         dpws_pkg::COND_SCALE_DIV: take = flags.scale_div;
         dpws_pkg::COND_DIV_BUSY:  take = flags.div_busy;
         dpws_pkg::COND_OUT_FULL:  take = flags.out_full;
         default:                  take = 1'b0;
      endcase
      upc_in = take ? word.target : upc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= dpws_pkg::UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl = word;

endmodule

[src/dual_pid_with_straightening_unit.sv]
// Top level of the dual PID drive controller: APB register file and microcoded datapath.
// Depends on dpws_pkg, dpws_req_if, dpws_rsp_if and dpws_seq.
//
//   Port group   Direction  Beat contents
//   req_bus      in         sensor_left, sensor_right
//   rsp_bus      out        drive_left, drive_right
//   psel ...     APB        eight control registers at byte offsets 0 to 28
//
// The longest path from acceptance of a sample pair to its response beat is the bit-serial
// divide of one side, one quotient bit per cycle. One multiplier serves every product.
// The sequencer accepts a new beat only at its idle step, and it holds before writing the
// response register while an earlier response is still waiting to be taken.
// Reset is synchronous and restores the register defaults and clears the error history.
module dual_pid_with_straightening_unit #(
   parameter int SENSOR_BITS = 12
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dpws_req_if.sink                             req_bus,
   dpws_rsp_if.source                           rsp_bus,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dpws_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dpws_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dpws_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);

   localparam int GW   = dpws_pkg::GAIN_BITS;
   localparam int F    = dpws_pkg::GAIN_FRAC_BITS;
   localparam int DB   = dpws_pkg::DRIVE_BITS;
   localparam int EW   = SENSOR_BITS + 1;
   localparam int OW   = SENSOR_BITS + 1;
   localparam int LW   = SENSOR_BITS + 2;
   localparam int DW   = EW + 1;
   localparam int TW   = dpws_pkg::TOTAL_BITS;
   localparam int TSW  = TW + 1;
   localparam int AW   = (TW > DW) ? TW : DW;
   localparam int SW   = AW + GW + 3;
   localparam int PW   = SW + GW + 1;
   localparam int CNTW = $clog2(SW + 1);
   localparam int WCW  = (EW > dpws_pkg::WINDOW_BITS) ? EW : dpws_pkg::WINDOW_BITS;

   localparam logic signed [PW-1:0]  BIAS_F   = PW'((64'd1 << F) - 64'd1);
   localparam logic signed [PW-1:0]  BIAS_2F  = PW'((64'd1 << (2 * F)) - 64'd1);
   localparam logic signed [PW-1:0]  SAT_HI   = PW'(dpws_pkg::DRIVE_MAX);
   localparam logic signed [DB-1:0]  DRV_HI   = DB'(dpws_pkg::DRIVE_MAX);
   localparam logic signed [WCW-1:0] WIN_LIM  = WCW'(dpws_pkg::ACCUM_WINDOW);

   // Control registers.
   logic [SENSOR_BITS-1:0] setpoint_ff [2];
   logic [GW-1:0]          gain_p_ff;
   logic [GW-1:0]          gain_i_ff;
   logic [GW-1:0]          gain_d_ff;
   logic [GW-1:0]          kgain_ff;
   logic [GW-1:0]          limit_ff;
   logic signed [OW-1:0]   offset_ff;

   // Error history that carries over from tick to tick.
   logic signed [TW-1:0]   total_ff [2];
   logic signed [TW-1:0]   total_in [2];
   logic signed [EW-1:0]   prev_ff  [2];
   logic signed [EW-1:0]   prev_in  [2];

   // Datapath working registers.
   logic [SENSOR_BITS-1:0] smp_ff [2];
   logic [SENSOR_BITS-1:0] smp_in [2];
   logic signed [EW-1:0]   e_ff,    e_in;
   logic signed [DW-1:0]   de_ff,   de_in;
   logic signed [TSW-1:0]  tsum_ff, tsum_in;
   logic signed [TW-1:0]   t_ff,    t_in;
   logic signed [PW-1:0]   prod_ff, prod_in;
   logic signed [SW-1:0]   acc_ff,  acc_in;
   logic signed [SW-1:0]   s_ff [2];
   logic signed [SW-1:0]   s_in [2];
   logic                   cmp_gt_ff, cmp_gt_in;
   logic                   cmp_lt_ff, cmp_lt_in;
   logic [SW-1:0]          dvd_ff,  dvd_in;
   logic [GW-1:0]          rem_ff,  rem_in;
   logic [CNTW-1:0]        cnt_ff,  cnt_in;
   logic                   dneg_ff, dneg_in;
   logic signed [DB-1:0]   drv_ff [2];
   logic signed [DB-1:0]   drv_in [2];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [DB-1:0]   rsp_left_ff,  rsp_left_in;
   logic signed [DB-1:0]   rsp_right_ff, rsp_right_in;

   // Combinational helpers.
   dpws_pkg::ctrl_word_type ctrl;
   dpws_pkg::seq_flags_type flags;
   logic                    sd;
   logic                    accept;
   logic                    cfg_wr;
   logic [dpws_pkg::REG_IDX_BITS-1:0] reg_idx;
   logic signed [EW-1:0]    e_new;
   logic signed [WCW-1:0]   e_win;
   logic                    in_win;
   logic signed [TSW-1:0]   lim_s;
   logic [GW-1:0]           kfix;
   logic signed [SW-1:0]    mul_a;
   logic signed [GW:0]      mul_b;
   logic signed [LW-1:0]    cmp_l;
   logic signed [LW-1:0]    cmp_r;
   logic signed [PW-1:0]    shr_src;
   logic signed [PW-1:0]    shr_sum_f;
   logic signed [PW-1:0]    shr_sum_2f;
   logic signed [PW-1:0]    shr_f;
   logic signed [PW-1:0]    shr_2f;
   logic signed [PW-1:0]    quo_s;
   logic signed [PW-1:0]    sv;
   logic signed [DB-1:0]    sat_v;
   logic [SW-1:0]           s_abs;
   logic [GW:0]             trial;
   logic                    fits;

   dpws_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign sd      = ctrl.side;
   assign accept  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (ctrl.op == dpws_pkg::OP_ACCEPT);

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.drive_left  = rsp_left_ff;
   assign rsp_bus.drive_right = rsp_right_ff;

   assign kfix = (kgain_ff == '0) ? GW'(1) : kgain_ff;

   always_comb begin
      flags.no_req    = !req_bus.valid;
      flags.scale_mul = sd ? cmp_lt_ff : cmp_gt_ff;
      flags.scale_div = sd ? cmp_gt_ff : cmp_lt_ff;
      flags.div_busy  = (cnt_ff != CNTW'(1));
      flags.out_full  = rsp_valid_ff;
   end

   // Register file.
   assign pready  = 1'b1;
   assign reg_idx = paddr[dpws_pkg::CSR_ADDR_BITS-1:2];
   assign cfg_wr  = psel && penable && pwrite;

   always_comb begin
      case (reg_idx)
         dpws_pkg::REG_SETPOINT_LEFT:     prdata = 32'(setpoint_ff[0]);
         dpws_pkg::REG_SETPOINT_RIGHT:    prdata = 32'(setpoint_ff[1]);
         dpws_pkg::REG_GAIN_P:            prdata = 32'(gain_p_ff);
         dpws_pkg::REG_GAIN_I:            prdata = 32'(gain_i_ff);
         dpws_pkg::REG_GAIN_D:            prdata = 32'(gain_d_ff);
         dpws_pkg::REG_STRAIGHTEN_GAIN:   prdata = 32'(kgain_ff);
         dpws_pkg::REG_INTEGRAL_LIMIT:    prdata = 32'(limit_ff);
         dpws_pkg::REG_STRAIGHTEN_OFFSET: prdata = 32'(offset_ff);
         default:                         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff[0] <= '0;
         setpoint_ff[1] <= '0;
         gain_p_ff      <= dpws_pkg::GAIN_P_RESET;
         gain_i_ff      <= dpws_pkg::GAIN_I_RESET;
         gain_d_ff      <= dpws_pkg::GAIN_D_RESET;
         kgain_ff       <= dpws_pkg::STRAIGHTEN_GAIN_RESET;
         limit_ff       <= dpws_pkg::INTEGRAL_LIMIT_RESET;
         offset_ff      <= OW'(dpws_pkg::OFFSET_RESET);
      end else if (cfg_wr) begin
         case (reg_idx)
            dpws_pkg::REG_SETPOINT_LEFT:     setpoint_ff[0] <= pwdata[SENSOR_BITS-1:0];
            dpws_pkg::REG_SETPOINT_RIGHT:    setpoint_ff[1] <= pwdata[SENSOR_BITS-1:0];
            dpws_pkg::REG_GAIN_P:            gain_p_ff      <= pwdata[GW-1:0];
            dpws_pkg::REG_GAIN_I:            gain_i_ff      <= pwdata[GW-1:0];
            dpws_pkg::REG_GAIN_D:            gain_d_ff      <= pwdata[GW-1:0];
            dpws_pkg::REG_STRAIGHTEN_GAIN:   kgain_ff       <= pwdata[GW-1:0];
            dpws_pkg::REG_INTEGRAL_LIMIT:    limit_ff       <= pwdata[GW-1:0];
            dpws_pkg::REG_STRAIGHTEN_OFFSET: offset_ff      <= signed'(pwdata[OW-1:0]);
            default: begin
               gain_p_ff <= gain_p_ff;
            end
         endcase
      end
   end

   // Shared arithmetic.
   always_comb begin
      e_new  = signed'({1'b0, setpoint_ff[sd]}) - signed'({1'b0, smp_ff[sd]});
      e_win  = WCW'(e_ff);
      in_win = (e_ff != '0) && (e_win < WIN_LIM) && (e_win > -WIN_LIM);
      lim_s  = signed'({2'b00, limit_ff});
      cmp_l  = signed'({2'b00, smp_ff[0]}) - LW'(offset_ff);
      cmp_r  = signed'({2'b00, smp_ff[1]});

      case (ctrl.op)
         dpws_pkg::OP_MUL_I: begin
            mul_a = SW'(t_ff);
            mul_b = signed'({1'b0, gain_i_ff});
         end
         dpws_pkg::OP_MUL_D: begin
            mul_a = SW'(de_ff);
            mul_b = signed'({1'b0, gain_d_ff});
         end
         dpws_pkg::OP_MUL_K: begin
            mul_a = s_ff[sd];
            mul_b = signed'({1'b0, kfix});
         end
         default: begin
            mul_a = SW'(e_ff);
            mul_b = signed'({1'b0, gain_p_ff});
         end
      endcase

      // Truncation toward zero: negative values get the divisor minus one added first.
      shr_src    = (ctrl.op == dpws_pkg::OP_OUT_MUL) ? prod_ff : PW'(s_ff[sd]);
      shr_sum_f  = shr_src + (shr_src[PW-1] ? BIAS_F : '0);
      shr_sum_2f = shr_src + (shr_src[PW-1] ? BIAS_2F : '0);
      shr_f      = shr_sum_f >>> F;
      shr_2f     = shr_sum_2f >>> (2 * F);
      quo_s      = dneg_ff ? -signed'(PW'(dvd_ff)) : signed'(PW'(dvd_ff));

      case (ctrl.op)
         dpws_pkg::OP_OUT_MUL: sv = shr_2f;
         dpws_pkg::OP_OUT_DIV: sv = quo_s;
         default:              sv = shr_f;
      endcase

      if (sv > SAT_HI) begin
         sat_v = DRV_HI;
      end else if (sv < -SAT_HI) begin
         sat_v = -DRV_HI;
      end else begin
         sat_v = sv[DB-1:0];
      end

      s_abs = s_ff[sd][SW-1] ? $unsigned(-s_ff[sd]) : $unsigned(s_ff[sd]);
      trial = {rem_ff, dvd_ff[SW-1]};
      fits  = (trial >= {1'b0, kfix});
   end

   // Next-state logic driven by the current control word.
   always_comb begin
      smp_in       = smp_ff;
      total_in     = total_ff;
      prev_in      = prev_ff;
      e_in         = e_ff;
      de_in        = de_ff;
      tsum_in      = tsum_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      cmp_gt_in    = cmp_gt_ff;
      cmp_lt_in    = cmp_lt_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      dneg_in      = dneg_ff;
      drv_in       = drv_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctrl.op inside {dpws_pkg::OP_MUL_P, dpws_pkg::OP_MUL_I, dpws_pkg::OP_MUL_D,
                          dpws_pkg::OP_MUL_K}) begin
         prod_in = mul_a * mul_b;
      end

      case (ctrl.op)
         dpws_pkg::OP_ACCEPT: begin
            if (accept) begin
               smp_in[0] = req_bus.sensor_left;
               smp_in[1] = req_bus.sensor_right;
            end
         end
         dpws_pkg::OP_ERR: begin
            e_in = e_new;
         end
         dpws_pkg::OP_TSUM: begin
            tsum_in = in_win ? TSW'(total_ff[sd]) + TSW'(e_ff) : '0;
            de_in   = DW'(e_ff) - DW'(prev_ff[sd]);
         end
         dpws_pkg::OP_CLAMP: begin
            if (tsum_ff > lim_s) begin
               t_in = TW'(lim_s);
            end else if (tsum_ff < -lim_s) begin
               t_in = TW'(-lim_s);
            end else begin
               t_in = TW'(tsum_ff);
            end
         end
         dpws_pkg::OP_MUL_I: begin
            acc_in = SW'(prod_ff);
         end
         dpws_pkg::OP_MUL_D: begin
            acc_in = acc_ff + SW'(prod_ff);
         end
         dpws_pkg::OP_SUM: begin
            s_in[sd]     = acc_ff + SW'(prod_ff);
            total_in[sd] = t_ff;
            prev_in[sd]  = e_ff;
         end
         dpws_pkg::OP_CMP: begin
            cmp_gt_in = (cmp_r > cmp_l);
            cmp_lt_in = (cmp_r < cmp_l);
         end
         dpws_pkg::OP_OUT_PLAIN, dpws_pkg::OP_OUT_MUL, dpws_pkg::OP_OUT_DIV: begin
            drv_in[sd] = sat_v;
         end
         dpws_pkg::OP_DIV_INIT: begin
            dvd_in  = s_abs;
            dneg_in = s_ff[sd][SW-1];
            rem_in  = '0;
            cnt_in  = CNTW'(SW);
         end
         dpws_pkg::OP_DIV_STEP: begin
            rem_in = fits ? GW'(trial - {1'b0, kfix}) : trial[GW-1:0];
            dvd_in = {dvd_ff[SW-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end
         dpws_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_left_in  = drv_ff[0];
            rsp_right_in = drv_ff[1];
         end
         default: begin
            e_in = e_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff[0]  <= '0;
         total_ff[1]  <= '0;
         prev_ff[0]   <= '0;
         prev_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         total_ff     <= total_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff       <= smp_in;
      e_ff         <= e_in;
      de_ff        <= de_in;
      tsum_ff      <= tsum_in;
      t_ff         <= t_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      s_ff         <= s_in;
      cmp_gt_ff    <= cmp_gt_in;
      cmp_lt_ff    <= cmp_lt_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      dneg_ff      <= dneg_in;
      drv_ff       <= drv_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
   end

endmodule

[verif/dual_pid_with_straightening_unit_tb.sv]
// Testbench for dual_pid_with_straightening_unit: drives sample pairs and APB register writes,
// predicts both drive commands in a scoreboard class and checks every response beat.
// Depends on dpws_pkg, dpws_req_if, dpws_rsp_if and the block itself.
`timescale 1ns / 1ps

module dual_pid_with_straightening_unit_tb;

   localparam int SENSOR_BITS     = 12;
   localparam int SENSOR_MAX      = (1 << SENSOR_BITS) - 1;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int DRAIN_CYCLES    = 80;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 125;

   typedef struct packed {
      logic signed [dpws_pkg::DRIVE_BITS-1:0] left;
      logic signed [dpws_pkg::DRIVE_BITS-1:0] right;
   } drive_pair_type;

   typedef enum {SCALE_PLAIN, SCALE_MUL, SCALE_DIV} scale_mode_type;

   class drive_scoreboard;
      int setpoint_left, setpoint_right;
      int gain_p, gain_i, gain_d;
      int straighten_gain, integral_limit, straighten_offset;
      int total_error[2];
      int last_error[2];
      drive_pair_type expected_drives[$];
      int mismatches;

      function void restore_defaults();
         setpoint_left     = 0;
         setpoint_right    = 0;
         gain_p            = int'(dpws_pkg::GAIN_P_RESET);
         gain_i            = int'(dpws_pkg::GAIN_I_RESET);
         gain_d            = int'(dpws_pkg::GAIN_D_RESET);
         straighten_gain   = int'(dpws_pkg::STRAIGHTEN_GAIN_RESET);
         integral_limit    = int'(dpws_pkg::INTEGRAL_LIMIT_RESET);
         straighten_offset = dpws_pkg::OFFSET_RESET;
         total_error       = '{0, 0};
         last_error        = '{0, 0};
      endfunction

      function void set_reg(logic [dpws_pkg::REG_IDX_BITS-1:0] idx,
                            logic [dpws_pkg::CSR_DATA_BITS-1:0] value);
         case (idx)
            dpws_pkg::REG_SETPOINT_LEFT:     setpoint_left = int'(value[11:0]);
            dpws_pkg::REG_SETPOINT_RIGHT:    setpoint_right = int'(value[11:0]);
            dpws_pkg::REG_GAIN_P:            gain_p = int'(value[15:0]);
            dpws_pkg::REG_GAIN_I:            gain_i = int'(value[15:0]);
            dpws_pkg::REG_GAIN_D:            gain_d = int'(value[15:0]);
            dpws_pkg::REG_STRAIGHTEN_GAIN:   straighten_gain = int'(value[15:0]);
            dpws_pkg::REG_INTEGRAL_LIMIT:    integral_limit = int'(value[15:0]);
            dpws_pkg::REG_STRAIGHTEN_OFFSET: straighten_offset = int'($signed(value[12:0]));
            default: ;
         endcase
      endfunction

      // The total error only accumulates inside the window; outside it, or at zero, it clears.
      function longint side_drive(int side, int setpoint, int pos);
         int     e;
         longint t;
         longint lim;
         longint s;
         e   = setpoint - pos;
         lim = integral_limit;
         if (e != 0 && e < dpws_pkg::ACCUM_WINDOW && e > -dpws_pkg::ACCUM_WINDOW)
            t = longint'(total_error[side]) + e;
         else
            t = 0;
         if (t > lim)
            t = lim;
         if (t < -lim)
            t = -lim;
         s = longint'(gain_p) * e + longint'(gain_i) * t
           + longint'(gain_d) * (e - last_error[side]);
         total_error[side] = int'(t);
         last_error[side]  = e;
         return s;
      endfunction

      function logic signed [dpws_pkg::DRIVE_BITS-1:0] shape_drive(longint s,
                                                                 scale_mode_type mode);
         longint k;
         longint unit;
         longint v;
         k    = (straighten_gain == 0) ? 1 : straighten_gain;
         unit = longint'(1) << dpws_pkg::GAIN_FRAC_BITS;
         case (mode)
            SCALE_MUL: v = (s * k) / (unit * unit);
            SCALE_DIV: v = s / k;
            default:   v = s / unit;
         endcase
         if (v > dpws_pkg::DRIVE_MAX)
            v = dpws_pkg::DRIVE_MAX;
         if (v < -dpws_pkg::DRIVE_MAX)
            v = -dpws_pkg::DRIVE_MAX;
         return v[dpws_pkg::DRIVE_BITS-1:0];
      endfunction

      function void note_sample(logic [SENSOR_BITS-1:0] left, logic [SENSOR_BITS-1:0] right);
         longint         s_left;
         longint         s_right;
         int             shifted_left;
         drive_pair_type want;
         s_left       = side_drive(dpws_pkg::SIDE_LEFT, setpoint_left, int'(left));
         s_right      = side_drive(dpws_pkg::SIDE_RIGHT, setpoint_right, int'(right));
         shifted_left = int'(left) - straighten_offset;
         if (int'(right) > shifted_left) begin
            want.left  = shape_drive(s_left, SCALE_MUL);
            want.right = shape_drive(s_right, SCALE_DIV);
         end else if (int'(right) < shifted_left) begin
            want.left  = shape_drive(s_left, SCALE_DIV);
            want.right = shape_drive(s_right, SCALE_MUL);
         end else begin
            want.left  = shape_drive(s_left, SCALE_PLAIN);
            want.right = shape_drive(s_right, SCALE_PLAIN);
         end
         expected_drives.push_back(want);
      endfunction

      task report(string msg);
         mismatches++;
         $display("mismatch at %0t: %s", $time, msg);
      endtask

      task check_drive(logic signed [dpws_pkg::DRIVE_BITS-1:0] left,
                       logic signed [dpws_pkg::DRIVE_BITS-1:0] right);
         drive_pair_type want;
         if (expected_drives.size() == 0) begin
            report($sformatf("drive beat %0d/%0d with no sample pending", left, right));
            return;
         end
         want = expected_drives.pop_front();
         if (left !== want.left)
            report($sformatf("drive_left %0d, predicted %0d", left, want.left));
         if (right !== want.right)
            report($sformatf("drive_right %0d, predicted %0d", right, want.right));
      endtask

      function int pending();
         return expected_drives.size();
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               psel;
   logic                               penable;
   logic                               pwrite;
   logic [dpws_pkg::CSR_ADDR_BITS-1:0] paddr;
   logic [dpws_pkg::CSR_DATA_BITS-1:0] pwdata;
   logic [dpws_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                               pready;

   dpws_req_if #(.SENSOR_BITS(SENSOR_BITS)) req_bus_if ();
   dpws_rsp_if rsp_bus_if ();

   drive_scoreboard sb = new();
   bit              calm;
   int              idle_cycles;

   dual_pid_with_straightening_unit #(.SENSOR_BITS(SENSOR_BITS)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus_if),
      .rsp_bus (rsp_bus_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #5 clock = ~clock;

   function automatic int pick_idle();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 90);
   endfunction

   function automatic int near_target(int centre);
      int v;
      v = centre + int'($urandom_range(0, 400)) - 200;
      if (v < 0)
         v = 0;
      if (v > SENSOR_MAX)
         v = SENSOR_MAX;
      return v;
   endfunction

   function automatic int pick_gain();
      if ($urandom_range(0, 99) < 75)
         return $urandom_range(0, 600);
      return $urandom_range(0, 65535);
   endfunction

   task automatic csr_write(logic [dpws_pkg::REG_IDX_BITS-1:0] idx,
                            logic [dpws_pkg::CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(idx, value);
   endtask

   task automatic csr_release();
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Valid is left high after the beat so that a following beat can go out without a gap.
   task automatic send_sample(int left, int right, int gap);
      if (gap > 0) begin
         req_bus_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus_if.valid        <= 1'b1;
      req_bus_if.sensor_left  <= left[SENSOR_BITS-1:0];
      req_bus_if.sensor_right <= right[SENSOR_BITS-1:0];
      do @(posedge clock); while (!(req_bus_if.valid && req_bus_if.ready));
      sb.note_sample(left[SENSOR_BITS-1:0], right[SENSOR_BITS-1:0]);
   endtask

   task automatic wait_drained();
      req_bus_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random();
      int r;
      int left;
      int right;
      r     = $urandom_range(0, 99);
      left  = near_target(sb.setpoint_left);
      right = near_target(sb.setpoint_right);
      if (r < 10) begin
         left  = sb.setpoint_left;
         right = sb.setpoint_right;
      end else if (r < 20) begin
         if (left - sb.straighten_offset >= 0 && left - sb.straighten_offset <= SENSOR_MAX)
            right = left - sb.straighten_offset;
      end else if (r < 32) begin
         left  = $urandom_range(0, SENSOR_MAX);
         right = $urandom_range(0, SENSOR_MAX);
      end
      send_sample(left, right, pick_idle());
   endtask

   task automatic configure_phase(int phase);
      int sp_left, sp_right, gp, gi, gd, sg, lim, off;
      sp_left  = $urandom_range(0, SENSOR_MAX);
      sp_right = $urandom_range(0, SENSOR_MAX);
      gp       = pick_gain();
      gi       = pick_gain();
      gd       = pick_gain();
      sg       = ($urandom_range(0, 99) < 85) ? $urandom_range(64, 1024)
                                              : $urandom_range(1, 65535);
      lim      = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3000)
                                              : $urandom_range(0, 65535);
      off      = ($urandom_range(0, 99) < 70) ? int'($urandom_range(0, 600)) - 300
                                              : int'($urandom_range(0, 8190)) - 4095;
      case (phase)
         0: begin
            sp_left = SENSOR_MAX; sp_right = SENSOR_MAX;
            gp = 65535; gi = 65535; gd = 65535;
            sg = 65535; lim = 65535; off = 4095;
         end
         1: begin
            sp_left = 0; sp_right = 0;
            gp = 0; gi = 0; gd = 0;
            sg = 0; lim = 0; off = -4095;
         end
         2: sg = 0;
         3: begin
            sg  = 1;
            off = -4095;
         end
         4: begin
            sg  = 65535;
            lim = 0;
         end
         default: ;
      endcase
      csr_write(dpws_pkg::REG_SETPOINT_LEFT, 32'(sp_left));
      csr_write(dpws_pkg::REG_SETPOINT_RIGHT, 32'(sp_right));
      csr_write(dpws_pkg::REG_GAIN_P, 32'(gp));
      csr_write(dpws_pkg::REG_GAIN_I, 32'(gi));
      csr_write(dpws_pkg::REG_GAIN_D, 32'(gd));
      csr_write(dpws_pkg::REG_STRAIGHTEN_GAIN, 32'(sg));
      csr_write(dpws_pkg::REG_INTEGRAL_LIMIT, 32'(lim));
      csr_write(dpws_pkg::REG_STRAIGHTEN_OFFSET, {19'b0, off[12:0]});
      csr_release();
   endtask

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus_if.valid && rsp_bus_if.ready)
            sb.check_drive(rsp_bus_if.drive_left, rsp_bus_if.drive_right);
         if (stall_left > 0) begin
            rsp_bus_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus_if.ready <= 1'b1;
            stall_left = pick_idle();
         end
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || psel || (req_bus_if.valid && req_bus_if.ready)
             || (rsp_bus_if.valid && rsp_bus_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      calm                    = 1'b0;
      reset                   <= 1'b1;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= '0;
      pwdata                  <= '0;
      req_bus_if.valid        <= 1'b0;
      req_bus_if.sensor_left  <= '0;
      req_bus_if.sensor_right <= '0;
      sb.restore_defaults();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: first tick with zero error, the equal-sides path, large errors
      // and the full sample range.
      send_sample(0, 0, pick_idle());
      send_sample(200, 0, pick_idle());
      send_sample(SENSOR_MAX, SENSOR_MAX, pick_idle());
      send_sample(SENSOR_MAX, 0, pick_idle());
      send_sample(0, SENSOR_MAX, pick_idle());
      send_sample(1, 1, pick_idle());
      send_sample(999, 999, pick_idle());
      send_sample(1000, 1000, pick_idle());
      send_sample(12'hAAA, 12'h555, pick_idle());
      send_sample(12'h555, 12'hAAA, pick_idle());
      wait_drained();

      // Mid-scale targets: errors at the accumulation window edges and clamping of the total.
      csr_write(dpws_pkg::REG_SETPOINT_LEFT, 32'd2048);
      csr_write(dpws_pkg::REG_SETPOINT_RIGHT, 32'd2048);
      csr_write(dpws_pkg::REG_GAIN_P, 32'd256);
      csr_write(dpws_pkg::REG_GAIN_I, 32'd256);
      csr_write(dpws_pkg::REG_GAIN_D, 32'd256);
      csr_write(dpws_pkg::REG_STRAIGHTEN_GAIN, 32'd512);
      csr_write(dpws_pkg::REG_INTEGRAL_LIMIT, 32'd1500);
      csr_write(dpws_pkg::REG_STRAIGHTEN_OFFSET, 32'd0);
      csr_release();
      send_sample(2048, 2048, pick_idle());
      send_sample(1049, 3047, pick_idle());
      send_sample(1049, 3047, pick_idle());
      send_sample(1049, 3047, pick_idle());
      send_sample(1048, 3048, pick_idle());
      send_sample(2047, 2049, pick_idle());
      send_sample(2049, 2047, pick_idle());
      send_sample(2050, 2050, pick_idle());
      send_sample(SENSOR_MAX, 0, pick_idle());
      send_sample(0, SENSOR_MAX, pick_idle());
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         calm = (phase % 4 == 3);
         configure_phase(phase);
         repeat (ITEMS_PER_PHASE) send_random();
         wait_drained();
      end
      calm = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
